>>> design/sbln_pkg.sv
// Shared constants, register codes and state type of the spectrum band level normalizer.
`timescale 1ns / 1ps
package sbln_pkg;

  localparam int NumBands  = 16;
  localparam int BandW     = 4;
  localparam int IdxW      = $clog2(NumBands);
  localparam int MagW      = 15;
  localparam int OffW      = 10;
  localparam int FracW     = 8;
  localparam int LevelW    = 8;
  localparam int ProdW     = MagW + FracW;
  localparam int CntW      = $clog2(FracW);
  localparam int L12Base   = 8;

  localparam int CfgAddrW  = 5;
  localparam int CfgDataW  = 32;

  localparam int InTdataW  = 24;
  localparam int OutTdataW = 40;
  localparam int OutTuserW = 2;

  localparam logic [OffW-1:0]   OffBand0Rst = OffW'(100);
  localparam logic [OffW-1:0]   OffBand1Rst = OffW'(50);
  localparam logic [OffW-1:0]   OffBand2Rst = OffW'(15);
  localparam logic [OffW-1:0]   OffBand3Rst = OffW'(10);
  localparam logic [OffW-1:0]   OffRestRst  = OffW'(3);
  localparam logic [FracW-1:0]  DecayRst    = FracW'(248);
  localparam logic [LevelW-1:0] FloorRst    = LevelW'(4);

  typedef enum logic [2:0] {
    RegOffBand0  = 3'd0,
    RegOffBand1  = 3'd1,
    RegOffBand2  = 3'd2,
    RegOffBand3  = 3'd3,
    RegOffRest   = 3'd4,
    RegPeakDecay = 3'd5,
    RegPeakFloor = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StPeak,
    StDiv,
    StDone
  } sbln_state_e;

endpackage

>>> design/spectrum_band_level_normalizer.sv
// Top level of the spectrum band level normalizer: registers, peak tracking and output stage.
//
//   Channel  Direction  Handshake          Payload
//   s_axis   in         tvalid / tready    tdata: band_index, magnitude
//   m_axis   out        tvalid / tready    tdata: result fields, tuser: view valid flags
//   apb      in         psel / penable     paddr, pwdata, prdata
//
// A request passes through acceptance, the serial peak-decay multiply, forming the peak,
// the serial divider, its registered done flag, and the result load.
// A band index out of range skips the arithmetic and goes from the multiply state straight to the result load.
// Reset clears the configuration to its defaults and all per-band peaks and levels to zero.
// A stalled result holds in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
module spectrum_band_level_normalizer import sbln_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // Fields from bit 0: band_index[3:0], magnitude[18:4], zero fill.
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // Fields from bit 0: out_band[3:0], level[11:4], at_peak[12], level8[20:13],
  // level12_index[24:21], level12[32:25], zero fill.
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // Fields from bit 0: level8_valid[0], level12_valid[1].
  output logic [OutTuserW-1:0] m_axis_tuser_o,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [CfgAddrW-1:0]  paddr_i,
  input  logic [CfgDataW-1:0]  pwdata_i,
  output logic [CfgDataW-1:0]  prdata_o,
  output logic                 pready_o
);

  sbln_state_e state_q, state_d;

  logic [OffW-1:0]   off0_q, off1_q, off2_q, off3_q, offr_q;
  logic [FracW-1:0]  decay_q;
  logic [LevelW-1:0] floor_q;
  logic              cfg_we;
  cfg_reg_e          cfg_sel;

  logic [MagW-1:0]   peak_mem_q [NumBands];
  logic [LevelW-1:0] level_mem_q [NumBands];

  logic [BandW-1:0]  in_band;
  logic [MagW-1:0]   in_mag;
  logic [OffW-1:0]   in_off;
  logic [MagW-1:0]   in_n;
  logic              accept;

  logic [BandW-1:0]  band_q;
  logic [MagW-1:0]   n_q;
  logic [MagW-1:0]   peak_q;
  logic [ProdW-1:0]  acc_q;
  logic [FracW-1:0]  dec_q;
  logic [CntW-1:0]   cnt_q;
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   idx_prev;
  logic              in_range;

  logic [MagW-1:0]   decayed;
  logic [MagW-1:0]   peak_d;
  logic [MagW-1:0]   max_dn;
  logic              div_start;
  logic              div_done;
  logic [LevelW-1:0] quot;

  logic              load_out;
  logic              mul_last;
  logic [LevelW-1:0] lvl_res;
  logic [LevelW:0]   pair_sum;
  logic              odd;

  logic [BandW-1:0]  ob_q;
  logic [LevelW-1:0] lvl_q, l8_q, l12_q;
  logic [BandW-1:0]  l12i_q;
  logic              atp_q, l8v_q, l12v_q, mvalid_q;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i;
  assign cfg_sel  = cfg_reg_e'(paddr_i[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off0_q  <= OffBand0Rst;
      off1_q  <= OffBand1Rst;
      off2_q  <= OffBand2Rst;
      off3_q  <= OffBand3Rst;
      offr_q  <= OffRestRst;
      decay_q <= DecayRst;
      floor_q <= FloorRst;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        RegOffBand0:  off0_q  <= pwdata_i[OffW-1:0];
        RegOffBand1:  off1_q  <= pwdata_i[OffW-1:0];
        RegOffBand2:  off2_q  <= pwdata_i[OffW-1:0];
        RegOffBand3:  off3_q  <= pwdata_i[OffW-1:0];
        RegOffRest:   offr_q  <= pwdata_i[OffW-1:0];
        RegPeakDecay: decay_q <= pwdata_i[FracW-1:0];
        RegPeakFloor: floor_q <= pwdata_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegOffBand0:  prdata_o = CfgDataW'(off0_q);
      RegOffBand1:  prdata_o = CfgDataW'(off1_q);
      RegOffBand2:  prdata_o = CfgDataW'(off2_q);
      RegOffBand3:  prdata_o = CfgDataW'(off3_q);
      RegOffRest:   prdata_o = CfgDataW'(offr_q);
      RegPeakDecay: prdata_o = CfgDataW'(decay_q);
      RegPeakFloor: prdata_o = CfgDataW'(floor_q);
      default:      prdata_o = '0;
    endcase
  end

  assign in_band = s_axis_tdata_i[BandW-1:0];
  assign in_mag  = s_axis_tdata_i[BandW+MagW-1:BandW];

  always_comb begin
    case (in_band)
      BandW'(0): in_off = off0_q;
      BandW'(1): in_off = off1_q;
      BandW'(2): in_off = off2_q;
      BandW'(3): in_off = off3_q;
      default:   in_off = offr_q;
    endcase
  end

  assign in_n = (in_mag > MagW'(in_off)) ? (in_mag - MagW'(in_off)) : '0;

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign idx      = band_q[IdxW-1:0];
  assign idx_prev = {band_q[IdxW-1:1], 1'b0};
  assign in_range = (int'(band_q) < NumBands);
  assign odd      = band_q[0];
  assign mul_last = (cnt_q == CntW'(FracW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StMul;
        end
      end
      StMul: begin
        if (!in_range) begin
          state_d = StDone;
        end else if (mul_last) begin
          state_d = StPeak;
        end
      end
      StPeak: begin
        div_start = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!mvalid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign decayed = acc_q[ProdW-1:FracW];
  assign max_dn  = (n_q > decayed) ? n_q : decayed;
  assign peak_d  = (MagW'(floor_q) > max_dn) ? MagW'(floor_q) : max_dn;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      band_q <= in_band;
      n_q    <= in_n;
      acc_q  <= '0;
      dec_q  <= decay_q;
      cnt_q  <= '0;
    end else if (state_q == StMul) begin
      acc_q <= {acc_q[ProdW-2:0], 1'b0}
             + (dec_q[FracW-1] ? ProdW'(peak_mem_q[idx]) : '0);
      dec_q <= {dec_q[FracW-2:0], 1'b0};
      cnt_q <= cnt_q + CntW'(1);
    end
    if (state_q == StPeak) begin
      peak_q <= peak_d;
    end
  end

  sbln_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (peak_d),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign lvl_res  = (peak_q == '0) ? '0 : quot;
  assign pair_sum = {1'b0, lvl_res} + {1'b0, level_mem_q[idx_prev]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBands; i++) begin
        peak_mem_q[i]  <= '0;
        level_mem_q[i] <= '0;
      end
    end else begin
      if (state_q == StPeak) begin
        peak_mem_q[idx] <= peak_d;
      end
      if (load_out && in_range) begin
        level_mem_q[idx] <= lvl_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q <= 1'b0;
    end else if (load_out) begin
      mvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      mvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ob_q <= band_q;
      if (!in_range) begin
        lvl_q  <= '0;
        atp_q  <= 1'b0;
        l8v_q  <= 1'b0;
        l8_q   <= '0;
        l12v_q <= 1'b0;
        l12i_q <= '0;
        l12_q  <= '0;
      end else begin
        lvl_q <= lvl_res;
        atp_q <= (n_q == peak_q);
        l8v_q <= odd;
        l8_q  <= odd ? pair_sum[LevelW:1] : '0;
        if (int'(band_q) < L12Base) begin
          l12v_q <= 1'b1;
          l12i_q <= band_q;
          l12_q  <= lvl_res;
        end else if (odd) begin
          l12v_q <= 1'b1;
          l12i_q <= BandW'(L12Base) + {2'b00, band_q[2:1]};
          l12_q  <= pair_sum[LevelW:1];
        end else begin
          l12v_q <= 1'b0;
          l12i_q <= '0;
          l12_q  <= '0;
        end
      end
    end
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {7'b0, l12_q, l12i_q, l8_q, atp_q, lvl_q, ob_q};
  assign m_axis_tuser_o  = {l12v_q, l8v_q};

  a_peak_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (peak_q >= MagW'(floor_q) && peak_q >= n_q))
    else $error("peak below floor or below magnitude");

  a_at_peak_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && atp_q) |-> (lvl_q == '1 || lvl_q == '0))
    else $error("at_peak set with a partial level");

  a_level8_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && l8v_q) |-> ob_q[0])
    else $error("eight-band value on an even band");

  a_level12_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && l12v_q && !l8v_q) |-> (int'(ob_q) < L12Base))
    else $error("twelve-band value on an even upper band");

endmodule

>>> design/sbln_div.sv
// Bit-serial restoring divider computing n * 255 / peak, one quotient bit per cycle.
`timescale 1ns / 1ps
module sbln_div import sbln_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MagW-1:0]   dividend_i,
  input  logic [MagW-1:0]   divisor_i,
  output logic              done_o,
  output logic [LevelW-1:0] quotient_o
);

  logic [MagW-1:0]   rem_q, rem_d;
  logic [LevelW-1:0] lo_q, lo_d;
  logic [LevelW-1:0] quot_q, quot_d;
  logic [MagW-1:0]   div_q, div_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ProdW-1:0]  prod;
  logic [MagW:0]     trial;
  logic [MagW:0]     diff;
  logic              take;

  // The quotient never exceeds 255 because n is never above the peak.
  assign prod  = {dividend_i, {FracW{1'b0}}} - {{FracW{1'b0}}, dividend_i};
  assign trial = {rem_q, lo_q[LevelW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign take  = (trial >= {1'b0, div_q});

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = prod[ProdW-1:FracW];
      lo_d   = prod[FracW-1:0];
      div_d  = divisor_i;
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = take ? diff[MagW-1:0] : trial[MagW-1:0];
      lo_d   = {lo_q[LevelW-2:0], 1'b0};
      quot_d = {quot_q[LevelW-2:0], take};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(LevelW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule
